// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the edge stream checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgse: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RGSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgse: next-cycle check failed");

`endif

// ===== design/rgse_pkg.sv =====
// ----------------------------------------------------------------------------
// rgse_pkg
// Widths, defaults and register indexes of the RGB to gray Sobel edge stream.
// ----------------------------------------------------------------------------
`default_nettype none

package rgse_pkg;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_COEFF_FRAC = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Register reset values and limits
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int MIN_DIM      = 3;

  // Largest edge value
  localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== design/rgse_stream_if.sv =====
// ----------------------------------------------------------------------------
// rgse_stream_if
// Valid/ready channels: RGB pixel input and edge result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgse_pix_if import rgse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgse_edge_if import rgse_pkg::*; #(
  parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_column;
  logic             last_in_run;
  logic             frame_done;

  modport source (output valid, output edge_value, output out_row, output out_column,
                  output last_in_run, output frame_done, input ready);
  modport sink   (input valid, input edge_value, input out_row, input out_column,
                  input last_in_run, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== design/rgb_gray_sobel_edge_stream.sv =====
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_stream
// Raster RGB to gray conversion followed by a 3x3 Sobel L1 edge magnitude.
// ----------------------------------------------------------------------------
// The block takes one RGB pixel per clock unless edge_o stalls. A pixel passes
// the stage 1 registers, the stage 2 window and the output register before
// its first result shows on edge_o. The last pixel of each row but row 0 and
// every pixel of the last row but column 0 cause extra border results; while
// those are sent pix_i.ready is low. Both line buffers live in one dual-port
// memory of MAX_WIDTH entries, 16 bits wide, read when a pixel is transferred
// and written back when it leaves stage 1. The memory is not cleared after
// reset; its entries are written by row 0 and row 1 of a frame before they
// are used. A write to either size register restarts the frame.
`default_nettype none

module rgb_gray_sobel_edge_stream import rgse_pkg::*; #(
  parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
  parameter int COEFF_FRACTION_BITS = DEF_COEFF_FRAC
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  rgse_pix_if.sink                  pix_i,
  rgse_edge_if.source               edge_o
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WCLAMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int FB       = COEFF_FRACTION_BITS;
  localparam int CW       = FB + 1;
  localparam int PW       = CW + PIX_W;
  localparam int SW       = PW + 2;
  localparam int GW       = SW - FB;
  localparam int DW       = PIX_W + 3;

  localparam longint unsigned CR = (64'd2126 * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam longint unsigned CG = (64'd7152 * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam longint unsigned CB = (64'd722  * (64'd1 << FB) + 64'd5000) / 64'd10000;
  localparam logic [CW-1:0] COEF_R = CW'(CR);
  localparam logic [CW-1:0] COEF_G = CW'(CG);
  localparam logic [CW-1:0] COEF_B = CW'(CB);

  // Size registers, kept as last index
  logic [COL_W-1:0]    w_last_q, w_last_d;
  logic [ROW_W-1:0]    h_last_q, h_last_d;
  logic [WCLAMP_W-1:0] w_req;
  logic [CFG_W-1:0]    h_req;

  // Raster position of the next input pixel
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // Stage 1: products and memory read
  logic             s1_valid_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PW-1:0]    s1_prod_r_q, s1_prod_g_q, s1_prod_b_q;
  logic [SW-1:0]    gray_sum;
  logic [PIX_W-1:0] gray;

  // Line buffers: {older row, newer row}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_q;
  logic [COL_W-1:0]   rd_addr;
  logic [PIX_W-1:0]   top_pix, mid_pix;

  // Stage 2: window and pending results {this row, row end, window}
  logic [PIX_W-1:0] win_q [9];
  logic [2:0]       s2_mask_q, s2_mask_d, s1_mask, s2_sel;
  logic [ROW_W-1:0] s2_row_q;
  logic [COL_W-1:0] s2_col_q;
  logic             s2_interior_q, s2_wrap_q;
  logic             s2_busy, s2_single;

  // Magnitude
  logic signed [DW-1:0] gx, gy;
  logic        [DW-1:0] ax, ay;
  logic        [DW:0]   mag;
  logic [PIX_W-1:0]     mag_sat;

  // Output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_edge_q, res_edge;
  logic [ROW_W-1:0] out_row_q, res_row;
  logic [COL_W-1:0] out_col_q, res_col;
  logic             out_last_q, out_frame_q;

  logic o_ok, adv, emit, accept;

  // Clamp incoming size values
  always_comb begin
    w_req = WCLAMP_W'(cfg_data_i);
    if (w_req < WCLAMP_W'(MIN_DIM)) begin
      w_req = WCLAMP_W'(MIN_DIM);
    end else if (w_req > WCLAMP_W'(MAX_WIDTH)) begin
      w_req = WCLAMP_W'(MAX_WIDTH);
    end
    h_req = (cfg_data_i < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : cfg_data_i;
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  w_last_d = COL_W'(w_req - WCLAMP_W'(1));
        CFG_IMAGE_HEIGHT: h_last_d = ROW_W'(h_req - CFG_W'(1));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= COL_W'(RESET_WIDTH - 1);
      h_last_q <= ROW_W'(RESET_HEIGHT - 1);
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
    end
  end

  // Flow control: stage 2 frees when its last pending result goes out
  assign o_ok      = !out_valid_q || edge_o.ready;
  assign s2_busy   = (s2_mask_q != 3'b000);
  assign s2_single = ((s2_mask_q & (s2_mask_q - 3'd1)) == 3'b000);
  assign adv       = !s2_busy || (s2_single && o_ok);
  assign emit      = s2_busy && o_ok;
  assign accept    = pix_i.valid && adv;
  assign pix_i.ready = adv;

  // Advance raster position per accepted pixel; restart on register write
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == w_last_q) begin
        col_d = '0;
        row_d = (row_q == h_last_q) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1 registers: weighted components and pixel position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q    <= row_q;
      s1_col_q    <= col_q;
      s1_prod_r_q <= PW'(COEF_R * pix_i.red);
      s1_prod_g_q <= PW'(COEF_G * pix_i.green);
      s1_prod_b_q <= PW'(COEF_B * pix_i.blue);
    end
  end

  // Gray value, truncated then saturated
  always_comb begin
    gray_sum = SW'(s1_prod_r_q) + SW'(s1_prod_g_q) + SW'(s1_prod_b_q);
    gray = (gray_sum[SW-1:FB] > GW'(EDGE_MAX)) ? EDGE_MAX : gray_sum[FB+PIX_W-1:FB];
  end

  // Read for the entering pixel; re-read the held one while stalled
  assign rd_addr = adv ? col_q : s1_col_q;
  assign top_pix = rd_data_q[2*PIX_W-1:PIX_W];
  assign mid_pix = rd_data_q[PIX_W-1:0];

  // Write back: older takes newer, newer takes gray
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && adv) begin
      line_mem[s1_col_q] <= {mid_pix, gray};
    end
    rd_data_q <= line_mem[rd_addr];
  end

  // Results due for the stage 1 pixel
  always_comb begin
    s1_mask[0] = (s1_row_q != '0) && (s1_col_q != '0);
    s1_mask[1] = (s1_row_q != '0) && (s1_col_q == w_last_q);
    s1_mask[2] = (s1_row_q == h_last_q);
  end

  // Stage 2 pending results: load on advance, drop each sent one
  assign s2_sel = s2_mask_q & (~s2_mask_q + 3'd1);

  always_comb begin
    s2_mask_d = s2_mask_q;
    if (adv) begin
      s2_mask_d = s1_valid_q ? s1_mask : 3'b000;
    end else if (emit) begin
      s2_mask_d = s2_mask_q & ~s2_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_mask_q <= 3'b000;
    end else begin
      s2_mask_q <= s2_mask_d;
    end
  end

  // Shift the 3x3 window one column per advancing pixel
  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_row_q      <= s1_row_q;
      s2_col_q      <= s1_col_q;
      s2_interior_q <= (s1_row_q >= ROW_W'(2)) && (s1_col_q >= COL_W'(2));
      s2_wrap_q     <= (s1_row_q == h_last_q) && (s1_col_q == w_last_q);
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= win_q[i+3];
      end
      win_q[6] <= top_pix;
      win_q[7] <= mid_pix;
      win_q[8] <= gray;
    end
  end

  // Sobel gradients and saturated L1 magnitude
  always_comb begin
    gx = signed'(DW'(win_q[6])) - signed'(DW'(win_q[0]))
       + ((signed'(DW'(win_q[7])) - signed'(DW'(win_q[1]))) <<< 1)
       + signed'(DW'(win_q[8])) - signed'(DW'(win_q[2]));
    gy = signed'(DW'(win_q[2])) - signed'(DW'(win_q[0]))
       + ((signed'(DW'(win_q[5])) - signed'(DW'(win_q[3]))) <<< 1)
       + signed'(DW'(win_q[8])) - signed'(DW'(win_q[6]));
    ax = (gx < 0) ? DW'(-gx) : DW'(gx);
    ay = (gy < 0) ? DW'(-gy) : DW'(gy);
    mag = (DW+1)'(ax) + (DW+1)'(ay);
    mag_sat = (mag > (DW+1)'(EDGE_MAX)) ? EDGE_MAX : mag[PIX_W-1:0];
  end

  // Select the next pending result
  always_comb begin
    res_edge = '0;
    res_row  = s2_row_q;
    res_col  = s2_col_q;
    unique case (1'b1)
      s2_sel[0]: begin
        res_edge = s2_interior_q ? mag_sat : '0;
        res_row  = s2_row_q - ROW_W'(1);
        res_col  = s2_col_q - COL_W'(1);
      end
      s2_sel[1]: begin
        res_row  = s2_row_q - ROW_W'(1);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_ok) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_edge_q  <= res_edge;
      out_row_q   <= res_row;
      out_col_q   <= res_col;
      out_last_q  <= s2_single;
      out_frame_q <= s2_wrap_q && s2_single;
    end
  end

  assign edge_o.valid       = out_valid_q;
  assign edge_o.edge_value  = out_edge_q;
  assign edge_o.out_row     = out_row_q;
  assign edge_o.out_column  = out_col_q;
  assign edge_o.last_in_run = out_last_q;
  assign edge_o.frame_done  = out_frame_q;

endmodule

`default_nettype wire

// ===== design/rgse_checker.sv =====
// ----------------------------------------------------------------------------
// rgse_checker
// Port-level checks on the edge result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgse_checker import rgse_pkg::*; #(
  parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [PIX_W-1:0] edge_value_i,
  input wire logic [COL_W-1:0] out_column_i,
  input wire logic             last_in_run_i,
  input wire logic             frame_done_i
);

  // Stalled result holds its value
  `RGSE_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(edge_value_i) && $stable(out_column_i))

  // Frame end closes the run of its pixel
  `RGSE_ASSERT_IMP(a_frame_last, clk_i, rst_ni, out_valid_i && frame_done_i, last_in_run_i)

  // Frame end is a border pixel
  `RGSE_ASSERT_IMP(a_frame_zero, clk_i, rst_ni, out_valid_i && frame_done_i, edge_value_i == '0)

  // Left column is border
  `RGSE_ASSERT_IMP(a_left_zero, clk_i, rst_ni, out_valid_i && (out_column_i == '0), edge_value_i == '0)

endmodule

bind rgb_gray_sobel_edge_stream rgse_checker #(
  .COL_W(COL_W)
) u_rgse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (edge_o.valid),
  .out_ready_i   (edge_o.ready),
  .edge_value_i  (edge_o.edge_value),
  .out_column_i  (edge_o.out_column),
  .last_in_run_i (edge_o.last_in_run),
  .frame_done_i  (edge_o.frame_done)
);

`default_nettype wire
